/* src/b64enc_pkg.sv */
// Shared types, constants and the sextet-to-character mapping for the base64 encoder.
// Used by every module under src; depends on nothing.
package b64enc_pkg;

    // One raw message byte with its end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // One output character with its group and message markers.
    typedef struct packed {
        logic [6:0] char_code;
        logic       group_end;
        logic       message_end;
    } char_item_t;

    // One closed group of up to three bytes, left aligned, with padding flags.
    typedef struct packed {
        logic [23:0] bits;
        logic        pad2;
        logic        pad3;
        logic        last;
    } group_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Group phase codes: number of bytes already held.
    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;
    localparam logic [1:0] PHASE_SPARE = 2'd3;

    // Character positions within a group.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_PLUS    = 7'h2B;
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;
    localparam logic [6:0] CHAR_PAD     = 7'h3D;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;

    // Standard alphabet lookup for one 6-bit value.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [5:0] off;
        off = 6'd0;
        if (v < SEXTET_LOWER_BASE) begin
            sextet_char = CHAR_UPPER_A + {1'b0, v};
        end
        else if (v < SEXTET_DIGIT_BASE) begin
            off = v - SEXTET_LOWER_BASE;
            sextet_char = CHAR_LOWER_A + {1'b0, off};
        end
        else if (v < SEXTET_PLUS) begin
            off = v - SEXTET_DIGIT_BASE;
            sextet_char = CHAR_ZERO + {1'b0, off};
        end
        else if (v == SEXTET_PLUS) begin
            sextet_char = CHAR_PLUS;
        end
        else begin
            sextet_char = CHAR_SLASH;
        end
    endfunction

endpackage

/* src/b64enc_front.sv */
// Front part: accepts raw bytes, packs up to three into each group and pushes closed groups.
// Depends on b64enc_pkg.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    input  q_status_t  q_status,
    output logic       push,
    output group_t     push_group
);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] held_reg, held_next;
    logic [1:0]  phase_eff;
    logic        accept;
    logic [7:0]  b;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;
    assign b          = byte_item.data_byte;

    always_comb begin
        phase_eff  = (phase_reg == PHASE_SPARE) ? PHASE_EMPTY : phase_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        push       = 1'b0;
        push_group = '0;
        if (accept) begin
            push_group.last = byte_item.last_byte;
            if (phase_eff == PHASE_EMPTY && !byte_item.last_byte) begin
                held_next  = {b, 8'h00};
                phase_next = PHASE_ONE;
            end
            else if (phase_eff == PHASE_ONE && !byte_item.last_byte) begin
                held_next  = {held_reg[15:8], b};
                phase_next = PHASE_TWO;
            end
            else begin
                push       = 1'b1;
                phase_next = PHASE_EMPTY;
                held_next  = 16'h0000;
                if (phase_eff == PHASE_EMPTY) begin
                    push_group.bits = {b, 16'h0000};
                    push_group.pad2 = 1'b1;
                    push_group.pad3 = 1'b1;
                end
                else if (phase_eff == PHASE_ONE) begin
                    push_group.bits = {held_reg[15:8], b, 8'h00};
                    push_group.pad3 = 1'b1;
                end
                else begin
                    push_group.bits = {held_reg, b};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PHASE_EMPTY;
            held_reg  <= 16'h0000;
        end
        else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // A byte that opens or extends a group never closes one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !byte_item.last_byte && phase_eff != PHASE_TWO) |-> !push)
        else $error("front pushed a group that was still filling");

endmodule

/* src/b64enc_queue.sv */
// Short register queue of closed groups between the front and back parts.
// Depends on b64enc_pkg.
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  group_t    push_group,
    input  logic      pop,
    output group_t    head,
    output q_status_t status
);

    group_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && status.full))
        else $error("group pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && status.empty))
        else $error("group popped from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

/* src/b64enc_back.sv */
// Back part: walks the head group one character per unstalled cycle into an output register.
// Depends on b64enc_pkg.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  group_t     head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_ready,
    output char_item_t char_item
);

    logic [1:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    char_item_t  out_item_reg;
    char_item_t  out_item_next;
    logic        load;
    logic [5:0]  sextet;
    logic        is_pad;

    assign load       = !q_status.empty && (!out_valid_reg || char_ready);
    assign pop        = load && (pos_reg == POS_FOURTH);
    assign char_valid = out_valid_reg;
    assign char_item  = out_item_reg;

    always_comb begin
        unique case (pos_reg)
            POS_FIRST:  sextet = head.bits[23:18];
            POS_SECOND: sextet = head.bits[17:12];
            POS_THIRD:  sextet = head.bits[11:6];
            POS_FOURTH: sextet = head.bits[5:0];
            default:    sextet = head.bits[5:0];
        endcase
        is_pad = (pos_reg == POS_THIRD && head.pad2) || (pos_reg == POS_FOURTH && head.pad3);
        out_item_next.char_code   = is_pad ? CHAR_PAD : sextet_char(sextet);
        out_item_next.group_end   = (pos_reg == POS_FOURTH);
        out_item_next.message_end = (pos_reg == POS_FOURTH) && head.last;

        pos_next       = load ? pos_reg + 1'b1 : pos_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !char_ready);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg       <= POS_FIRST;
            out_valid_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_item_reg <= out_item_next;
        end
    end

    // A message can only end on the closing character of a group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.message_end) |-> out_item_reg.group_end)
        else $error("message end outside a group end");

    // The character position returns to the first one exactly when a group leaves the queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> (pos_reg == POS_FIRST))
        else $error("character position out of step with group pops");

endmodule

/* src/base64_encoder.sv */
// Base64 encoder (standard alphabet, '=' padding), one raw byte in, one character out per item.
// Flow: a byte that closes a group is written into the queue, and the back then loads its first
//   character into the output register; its characters follow one per cycle when not stalled.
// Throughput: bytes are taken every cycle while the two-group queue has room; the sustained
//   rate is one character per cycle from the single output register while char_ready holds.
// Reset (rst_n, asynchronous, active low) clears the group phase, held bytes and the queue.
module base64_encoder
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    output logic       char_valid,
    input  logic       char_ready,
    output char_item_t char_item
);

    // The front collects bytes into groups; a group is pushed when its third byte
    // arrives or when a byte marked last closes it early with padding.
    logic      push;
    group_t    push_group;
    logic      pop;
    group_t    head;
    q_status_t q_status;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    // The queue decouples byte acceptance from character output, so the front keeps
    // taking bytes while the back drains a group or waits on a stalled consumer.
    b64enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // The back turns the head group into four characters, one per cycle unless the output
    // stalls; it frees the queue entry as the fourth character enters the output register.
    b64enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

endmodule
